// ----- sv/rnef_pkg.sv -----
// Shared constants, types and state codes of the radius neighbor edge finder.
package rnef_pkg;

    // Point store geometry.
    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int MAX_DIMS   = 4;

    // Coordinate and distance arithmetic.
    localparam int COORD_FIELD_W = 16;
    localparam int COORD_BITS    = 16;
    localparam int POINT_W       = MAX_DIMS * COORD_BITS;
    localparam int SQ_W          = 2 * COORD_BITS;
    localparam int SUM_W         = SQ_W + $clog2(MAX_DIMS) + 1;
    localparam int DIST_W        = 36;

    // Configuration registers.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 36;
    localparam int DIMS_W     = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIMS_IN_USE    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_SQUARED = CFG_IDX_W'(1);
    localparam logic [DIMS_W-1:0]    DIMS_RESET         = DIMS_W'(3);

    // Result queue.
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int CREDIT_W   = FIFO_CNT_W + 1;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    // Valid flag and stored-point index that travel with a compare.
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
    } rnef_tag_t;

    // One result word.
    typedef struct packed {
        logic [IDX_W-1:0] earlier;
        logic [IDX_W-1:0] newer;
        logic             last;
        logic             ovf;
    } rnef_result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OVF,
        ST_SWEEP,
        ST_DRAIN,
        ST_FLUSH
    } rnef_state_t;

endpackage

// ----- sv/radius_neighbor_edge_finder_unit.sv -----
// Fixed-radius near-neighbor edge finder: top level with sweep control and result queue.
//
// Input channel (s_): one point word per handshake, up to four signed coordinates
// and a first_point flag that empties the store so the point gets index 0.
// Result channel (m_): edge words (earlier index, new index); last_edge marks the
// final word caused by one point. A point that arrives with the store full is
// dropped and gives one word with overflow and last_edge set.
// Configuration channel (cfg_): index 0 is dims_in_use, index 1 is radius_squared;
// writes are always taken and should only happen while the block is idle.
// Sweep: while the queue has room, the store is read one stored point per cycle through
// the single memory read port, then a three-stage distance pipeline drains. A point is
// accepted only when the previous sweep ends.
// Edge words: a neighbor's word is queued when the next neighbor's compare ends; the last
// word is queued by the flush once the pipeline has drained.
// Results sit in a 16-word queue, so a new point is taken while earlier words
// wait; when the receiver stalls, the sweep pauses once the queue has no room.
// Reset: clears the point count, the queue and the configuration to its defaults.
// The point store itself is not cleared; only entries written since are read.
module radius_neighbor_edge_finder_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_first_point,
    input  logic signed [rnef_pkg::COORD_FIELD_W-1:0] s_coord_0,
    input  logic signed [rnef_pkg::COORD_FIELD_W-1:0] s_coord_1,
    input  logic signed [rnef_pkg::COORD_FIELD_W-1:0] s_coord_2,
    input  logic signed [rnef_pkg::COORD_FIELD_W-1:0] s_coord_3,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [rnef_pkg::IDX_W-1:0]            m_earlier_index,
    output logic [rnef_pkg::IDX_W-1:0]            m_new_index,
    output logic                                  m_last_edge,
    output logic                                  m_overflow,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [rnef_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rnef_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import rnef_pkg::*;

    rnef_state_t                 state_reg, state_next;
    logic [CNT_W-1:0]            count_reg;
    logic [DIMS_W-1:0]           dims_cfg_reg;
    logic [DIST_W-1:0]           radius_reg;
    logic [IDX_W-1:0]            idx_reg;
    coord_t [MAX_DIMS-1:0]       point_reg;
    logic [MAX_DIMS-1:0]         lane_en_reg;
    logic [MAX_DIMS-1:0]         lane_en_next;
    logic [CNT_W-1:0]            u_reg;
    rnef_tag_t                   rd_tag_reg;
    logic                        pend_valid_reg;
    logic [IDX_W-1:0]            pend_idx_reg;
    rnef_result_t                fifo_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]       wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]       rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]       fifo_cnt_reg;

    logic [COORD_FIELD_W-1:0]    coord_in [MAX_DIMS];
    logic [POINT_W-1:0]          wr_point;
    coord_t [MAX_DIMS-1:0]       point_next;
    logic                        in_fire;
    logic                        cfg_fire;
    logic [CNT_W-1:0]            count_eff;
    logic                        store_full;
    logic                        sweep_done;
    logic                        credit_ok;
    logic [CREDIT_W-1:0]         credit_need;
    logic                        issue;
    logic [POINT_W-1:0]          rd_point;
    rnef_tag_t                   cmp_tag;
    logic [SUM_W-1:0]            dist_sum;
    logic [1:0]                  pipe_busy;
    logic                        pipe_empty;
    logic                        hit;
    logic                        fifo_full;
    logic                        push;
    logic                        push_hit;
    logic                        push_flush;
    logic                        push_ovf;
    logic                        pop;
    rnef_result_t                push_word;
    rnef_result_t                head_word;

    // Input coordinates as a lane array, low COORD_BITS bits of each field.
    assign coord_in[0] = s_coord_0;
    assign coord_in[1] = s_coord_1;
    assign coord_in[2] = s_coord_2;
    assign coord_in[3] = s_coord_3;

    always_comb begin
        for (int d = 0; d < MAX_DIMS; d++) begin
            point_next[d] = coord_t'(coord_in[d][COORD_BITS-1:0]);
            wr_point[d*COORD_BITS +: COORD_BITS] = coord_in[d][COORD_BITS-1:0];
            // Zero dims acts as one, and values above the lane count enable all lanes.
            lane_en_next[d] = (d == 0) || (DIMS_W'(d) < dims_cfg_reg);
        end
    end

    // Handshakes and index of the incoming point.
    assign in_fire    = s_valid && s_ready;
    assign cfg_fire   = cfg_valid && cfg_ready;
    assign count_eff  = s_first_point ? '0 : count_reg;
    assign store_full = (count_eff == CNT_W'(MAX_POINTS));
    assign sweep_done = (u_reg == CNT_W'(idx_reg));
    assign pipe_empty = !rd_tag_reg.valid && (pipe_busy == 2'd0);

    // Reserve queue room for every compare in flight plus the final flush.
    assign credit_need = CREDIT_W'(fifo_cnt_reg) + CREDIT_W'(rd_tag_reg.valid)
                       + CREDIT_W'(pipe_busy) + CREDIT_W'(pend_valid_reg)
                       + CREDIT_W'(2);
    assign credit_ok   = (credit_need <= CREDIT_W'(FIFO_DEPTH));

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = store_full ? ST_OVF : ST_SWEEP;
                end
            end
            ST_OVF: begin
                if (!fifo_full) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SWEEP: begin
                if (sweep_done) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (pipe_empty) begin
                    state_next = pend_valid_reg ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (!fifo_full) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        s_ready    = 1'b0;
        issue      = 1'b0;
        push_flush = 1'b0;
        push_ovf   = 1'b0;
        cfg_ready  = 1'b1;
        unique case (state_reg)
            ST_IDLE:  s_ready    = 1'b1;
            ST_OVF:   push_ovf   = !fifo_full;
            ST_SWEEP: issue      = !sweep_done && credit_ok;
            ST_DRAIN: issue      = 1'b0;
            ST_FLUSH: push_flush = !fifo_full;
            default:  s_ready    = 1'b0;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            dims_cfg_reg     <= DIMS_RESET;
            radius_reg       <= '0;
            rd_tag_reg.valid <= 1'b0;
            pend_valid_reg   <= 1'b0;
        end else begin
            state_reg        <= state_next;
            rd_tag_reg.valid <= issue;
            if (in_fire) begin
                count_reg <= store_full ? count_eff : count_eff + CNT_W'(1);
            end
            if (cfg_fire) begin
                if (cfg_index == CFG_DIMS_IN_USE) begin
                    dims_cfg_reg <= cfg_data[DIMS_W-1:0];
                end else if (cfg_index == CFG_RADIUS_SQUARED) begin
                    radius_reg <= cfg_data[DIST_W-1:0];
                end
            end
            if (hit) begin
                pend_valid_reg <= 1'b1;
            end else if (push_flush) begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    // Sweep payload registers.
    always_ff @(posedge aclk) begin
        rd_tag_reg.idx <= u_reg[IDX_W-1:0];
        if (in_fire) begin
            idx_reg     <= count_eff[IDX_W-1:0];
            point_reg   <= point_next;
            lane_en_reg <= lane_en_next;
            u_reg       <= '0;
        end else if (issue) begin
            u_reg <= u_reg + CNT_W'(1);
        end
        if (hit) begin
            pend_idx_reg <= cmp_tag.idx;
        end
    end

    // Point store: the new point is written at accept, the sweep reads older entries.
    rnef_point_ram #(
        .DEPTH (MAX_POINTS),
        .WIDTH (POINT_W)
    ) u_point_ram (
        .aclk  (aclk),
        .we    (in_fire && !store_full),
        .waddr (count_eff[IDX_W-1:0]),
        .wdata (wr_point),
        .re    (issue),
        .raddr (u_reg[IDX_W-1:0]),
        .rdata (rd_point)
    );

    // Squared distance of each stored point to the new point.
    rnef_dist_pipe u_dist_pipe (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_tag       (rd_tag_reg),
        .stored_point (rd_point),
        .new_point    (point_reg),
        .lane_en      (lane_en_reg),
        .out_tag      (cmp_tag),
        .dist_sum     (dist_sum),
        .busy_cnt     (pipe_busy)
    );

    // A neighbor within the radius; the previous neighbor is then known not to be last.
    assign hit      = cmp_tag.valid && (DIST_W'(dist_sum) <= radius_reg);
    assign push_hit = hit && pend_valid_reg;
    assign push     = push_hit || push_flush || push_ovf;

    always_comb begin
        if (push_ovf) begin
            push_word.earlier = '0;
            push_word.newer   = '0;
            push_word.last    = 1'b1;
            push_word.ovf     = 1'b1;
        end else begin
            push_word.earlier = pend_idx_reg;
            push_word.newer   = idx_reg;
            push_word.last    = push_flush;
            push_word.ovf     = 1'b0;
        end
    end

    // Result queue.
    assign fifo_full = (fifo_cnt_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign pop       = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            priority if (push && !pop) begin
                fifo_cnt_reg <= fifo_cnt_reg + FIFO_CNT_W'(1);
            end else if (pop && !push) begin
                fifo_cnt_reg <= fifo_cnt_reg - FIFO_CNT_W'(1);
            end
        end
    end

    assign head_word       = fifo_reg[rd_ptr_reg];
    assign m_valid         = (fifo_cnt_reg != '0);
    assign m_earlier_index = head_word.earlier;
    assign m_new_index     = head_word.newer;
    assign m_last_edge     = head_word.last;
    assign m_overflow      = head_word.ovf;

endmodule

// ----- sv/rnef_point_ram.sv -----
// Simple dual-port point store with registered read.
module rnef_point_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_array[waddr] <= wdata;
        end
    end

    // Read port with registered data.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/rnef_dist_pipe.sv -----
// Three-stage squared-distance pipeline: difference magnitude, square, lane sum.
module rnef_dist_pipe (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  rnef_pkg::rnef_tag_t                         in_tag,
    input  logic [rnef_pkg::POINT_W-1:0]                stored_point,
    input  rnef_pkg::coord_t [rnef_pkg::MAX_DIMS-1:0]   new_point,
    input  logic [rnef_pkg::MAX_DIMS-1:0]               lane_en,
    output rnef_pkg::rnef_tag_t                         out_tag,
    output logic [rnef_pkg::SUM_W-1:0]                  dist_sum,
    output logic [1:0]                                  busy_cnt
);
    import rnef_pkg::*;

    logic signed [COORD_BITS:0] diff     [MAX_DIMS];
    logic [COORD_BITS:0]        neg_diff [MAX_DIMS];
    logic [COORD_BITS-1:0]      mag_next [MAX_DIMS];
    logic [COORD_BITS-1:0]      mag_reg  [MAX_DIMS];
    logic [SQ_W-1:0]            sq_next  [MAX_DIMS];
    logic [SQ_W-1:0]            sq_reg   [MAX_DIMS];
    logic [SUM_W-1:0]           sum_next;
    logic [SUM_W-1:0]           sum_reg;
    rnef_tag_t                  tag_a_reg;
    rnef_tag_t                  tag_b_reg;
    rnef_tag_t                  tag_c_reg;

    // Per-lane difference magnitude; lanes beyond the active count give zero.
    always_comb begin
        for (int d = 0; d < MAX_DIMS; d++) begin
            diff[d] = $signed({new_point[d][COORD_BITS-1], new_point[d]})
                    - $signed({stored_point[d*COORD_BITS+COORD_BITS-1],
                               stored_point[d*COORD_BITS +: COORD_BITS]});
            neg_diff[d] = -diff[d];
            if (!lane_en[d]) begin
                mag_next[d] = '0;
            end else if (diff[d][COORD_BITS]) begin
                mag_next[d] = neg_diff[d][COORD_BITS-1:0];
            end else begin
                mag_next[d] = diff[d][COORD_BITS-1:0];
            end
        end
    end

    // Per-lane square of the magnitude.
    always_comb begin
        for (int d = 0; d < MAX_DIMS; d++) begin
            sq_next[d] = SQ_W'(mag_reg[d]) * SQ_W'(mag_reg[d]);
        end
    end

    // Sum of the lane squares.
    always_comb begin
        sum_next = '0;
        for (int d = 0; d < MAX_DIMS; d++) begin
            sum_next = sum_next + SUM_W'(sq_reg[d]);
        end
    end

    // Stage valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_a_reg.valid <= 1'b0;
            tag_b_reg.valid <= 1'b0;
            tag_c_reg.valid <= 1'b0;
        end else begin
            tag_a_reg.valid <= in_tag.valid;
            tag_b_reg.valid <= tag_a_reg.valid;
            tag_c_reg.valid <= tag_b_reg.valid;
        end
    end

    // Stage payload.
    always_ff @(posedge aclk) begin
        tag_a_reg.idx <= in_tag.idx;
        tag_b_reg.idx <= tag_a_reg.idx;
        tag_c_reg.idx <= tag_b_reg.idx;
        mag_reg       <= mag_next;
        sq_reg        <= sq_next;
        sum_reg       <= sum_next;
    end

    assign out_tag  = tag_c_reg;
    assign dist_sum = sum_reg;
    assign busy_cnt = {1'b0, tag_a_reg.valid} + {1'b0, tag_b_reg.valid}
                    + {1'b0, tag_c_reg.valid};

endmodule

// ----- sv/rnef_checker.sv -----
// Port-level checker for the edge finder and its bind to the top level.
module rnef_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [rnef_pkg::IDX_W-1:0]        m_earlier_index,
    input logic [rnef_pkg::IDX_W-1:0]        m_new_index,
    input logic                              m_last_edge,
    input logic                              m_overflow
);

    // A stalled result word holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_earlier_index)
            && $stable(m_new_index) && $stable(m_last_edge) && $stable(m_overflow))
        else $error("result word changed while stalled");

    // An overflow word is a single, last word with zero indexes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overflow |-> m_last_edge && (m_earlier_index == '0)
            && (m_new_index == '0))
        else $error("malformed overflow word");

    // An edge always points back to an earlier stored point.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_overflow |-> (m_earlier_index < m_new_index))
        else $error("edge earlier index not below new index");

    // A taken point closes the input until its sweep is over.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after a point was taken");

    // Reset leaves no result pending.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind radius_neighbor_edge_finder_unit rnef_checker u_rnef_checker (.*);
